// ----- rtl/i2cbs_pkg.sv -----
// Shared types and constants of the I2C master bit sequencer.
`timescale 1ns / 1ps
package i2cbs_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT   = 1'd1;

  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 16'd8;
  localparam logic [CFG_W-1:0] ACK_WAIT_RST   = 16'd2550;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_word_t;

endpackage

// ----- rtl/i2cbs_chan_if.sv -----
// Valid/ready channel carrying one word of the I2C master bit sequencer.
`timescale 1ns / 1ps
interface i2cbs_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/i2c_master_bit_sequencer_unit.sv -----
// Top level of the I2C master bit sequencer: command sequencing and result register.
`timescale 1ns / 1ps
// Open-drain I2C master stepped by one input word per time tick. Each input word may carry
// a command (start, stop, write byte, read byte), taken only while the sequencer is idle,
// plus the sampled SDA level; each accepted word gives exactly one result word with the
// SCL and SDA drive levels, busy and done flags, the last received byte and the ACK result
// of the last write. Every line change is held for hold_ticks words (0 acts as 1); a write
// waits up to ack_wait_limit+1 words for the slave ACK. While the sink takes results,
// throughput is one word per clock: the whole step is a single pass of logic from the
// state registers into the result register, so the word accepted on one edge is offered
// on out_ch from the next cycle. in_ch.ready is low only while the result register holds
// a word the sink has not taken. Configuration writes (cfg_idx 0 hold_ticks, 1
// ack_wait_limit) take effect at once and are meant to be issued with the sequencer idle.
module i2c_master_bit_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  i2cbs_chan_if.sink                       in_ch,
  i2cbs_chan_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [i2cbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [i2cbs_pkg::CFG_W-1:0]      cfg_wdata
);
  import i2cbs_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S1, PH_S2, PH_S3, PH_S4, PH_P1, PH_P2, PH_P3,
    PH_W0, PH_WD, PH_WH, PH_WL, PH_WR, PH_WA, PH_WAH, PH_WE,
    PH_R0, PH_RL, PH_RH, PH_RA0, PH_RA1, PH_RA2, PH_RA3
  } phase_t;

  // configuration
  logic [CFG_W-1:0] hold_ticks_r;
  logic [CFG_W-1:0] ack_wait_r;

  // sequencer state
  phase_t           phase_r, phase_nxt;
  logic [CFG_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [3:0]       bit_idx_r, bit_idx_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             nack_r, nack_nxt;
  logic             ack_r, ack_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic [7:0]       rx_last_r, rx_last_nxt;
  logic             done;

  // result register
  logic             out_valid_r;
  out_word_t        out_data_r;
  out_word_t        res;

  in_word_t         iw;
  logic             in_acc;
  logic [3:0]       bit_inc;

  assign iw          = in_ch.data;
  // Accept whenever the result register is empty or being emptied this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign bit_inc     = bit_idx_r + 4'd1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // One tick of the sequencer.
  always_comb begin
    phase_nxt    = phase_r;
    hold_cnt_nxt = hold_cnt_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    nack_nxt     = nack_r;
    ack_nxt      = ack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    rx_last_nxt  = rx_last_r;
    done         = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (iw.cmd_valid) begin
        hold_cnt_nxt = hold_ticks_r;
        unique case (cmd_t'(iw.cmd))
          CMD_START: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_S1;
          end
          CMD_STOP: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_P1;
          end
          CMD_WRITE: begin
            shift_nxt   = iw.tx_byte;
            bit_idx_nxt = 4'd0;
            ack_nxt     = 1'b0;
            scl_nxt     = 1'b0;
            phase_nxt   = PH_W0;
          end
          CMD_READ: begin
            nack_nxt    = iw.send_nack;
            shift_nxt   = 8'd0;
            bit_idx_nxt = 4'd0;
            sda_nxt     = 1'b1;
            phase_nxt   = PH_R0;
          end
          default: ;
        endcase
      end
    end else if (phase_r == PH_WA) begin
      // ACK slot: count up until the slave pulls SDA low or the limit is reached
      if (!iw.sda_in) begin
        ack_nxt      = 1'b1;
        phase_nxt    = PH_WAH;
        hold_cnt_nxt = hold_ticks_r;
      end else if (hold_cnt_r >= ack_wait_r) begin
        ack_nxt      = 1'b0;
        phase_nxt    = PH_WAH;
        hold_cnt_nxt = hold_ticks_r;
      end else begin
        hold_cnt_nxt = hold_cnt_r + 16'd1;
      end
    end else if (hold_cnt_r > 16'd1) begin
      hold_cnt_nxt = hold_cnt_r - 16'd1;
    end else begin
      hold_cnt_nxt = hold_ticks_r;
      unique case (phase_r)
        PH_S1:  begin scl_nxt = 1'b1; phase_nxt = PH_S2; end
        PH_S2:  begin sda_nxt = 1'b0; phase_nxt = PH_S3; end
        PH_S3:  begin scl_nxt = 1'b0; phase_nxt = PH_S4; end
        PH_P1:  begin scl_nxt = 1'b1; phase_nxt = PH_P2; end
        PH_P2:  begin sda_nxt = 1'b1; phase_nxt = PH_P3; end
        PH_W0, PH_WL: begin
          // Set the next data bit while SCL is low, or release SDA for the ACK slot
          if (bit_idx_r < BYTE_BITS) begin
            sda_nxt     = shift_r[7];
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_inc;
            phase_nxt   = PH_WD;
          end else begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_WR;
          end
        end
        PH_WD:  begin scl_nxt = 1'b1; phase_nxt = PH_WH; end
        PH_WH:  begin scl_nxt = 1'b0; phase_nxt = PH_WL; end
        PH_WR: begin
          scl_nxt      = 1'b1;
          phase_nxt    = PH_WA;
          hold_cnt_nxt = '0;
        end
        PH_WAH: begin scl_nxt = 1'b0; phase_nxt = PH_WE; end
        PH_R0:  begin scl_nxt = 1'b0; phase_nxt = PH_RL; end
        PH_RL:  begin scl_nxt = 1'b1; phase_nxt = PH_RH; end
        PH_RH: begin
          // Sample on the last tick of the SCL-high hold
          shift_nxt   = {shift_r[6:0], iw.sda_in};
          bit_idx_nxt = bit_inc;
          scl_nxt     = 1'b0;
          phase_nxt   = (bit_inc < BYTE_BITS) ? PH_RL : PH_RA0;
        end
        PH_RA0: begin sda_nxt = nack_r; phase_nxt = PH_RA1; end
        PH_RA1: begin scl_nxt = 1'b1; phase_nxt = PH_RA2; end
        PH_RA2: begin scl_nxt = 1'b0; phase_nxt = PH_RA3; end
        PH_RA3: begin
          rx_last_nxt  = shift_r;
          phase_nxt    = PH_IDLE;
          hold_cnt_nxt = '0;
          done         = 1'b1;
        end
        default: begin
          // End of start, stop and write
          phase_nxt    = PH_IDLE;
          hold_cnt_nxt = '0;
          done         = 1'b1;
        end
      endcase
    end

    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = rx_last_nxt;
    res.ack_seen  = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_TICKS_RST;
      ack_wait_r   <= ACK_WAIT_RST;
      phase_r      <= PH_IDLE;
      hold_cnt_r   <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      nack_r       <= 1'b0;
      ack_r        <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      rx_last_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata;
          CFG_ACK_WAIT:   ack_wait_r   <= cfg_wdata;
          default: ;
        endcase
      end
      // Advance state and load the result word together
      if (in_acc) begin
        phase_r     <= phase_nxt;
        hold_cnt_r  <= hold_cnt_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        nack_r      <= nack_nxt;
        ack_r       <= ack_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        rx_last_r   <= rx_last_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- rtl/i2cbs_checker.sv -----
// Port-level checks of the I2C master bit sequencer and their binding.
`timescale 1ns / 1ps
module i2cbs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cbs_pkg::out_word_t out_data
);
  import i2cbs_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // never refuse input while the result register is empty
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty result register");

  // an accepted word shows up as a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // completion is reported with the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done flagged while busy");

endmodule

bind i2c_master_bit_sequencer_unit i2cbs_checker u_i2cbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- test/i2cbs_bus_checker.sv -----
// Scoreboard for the I2C master bit sequencer: predicts every result word and compares.
`timescale 1ns / 1ps
module i2cbs_bus_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  i2cbs_pkg::in_word_t             in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  i2cbs_pkg::out_word_t            out_data,
  input  logic                            cfg_we,
  input  logic [i2cbs_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [i2cbs_pkg::CFG_W-1:0]     cfg_wdata,
  output int                              mismatches,
  output int                              pending_results
);
  import i2cbs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_STA_RISE, ST_STA_SDA_LOW, ST_STA_SCL_LOW, ST_STA_END,
    ST_STO_RISE, ST_STO_SDA_REL, ST_STO_END,
    ST_WR_BEGIN, ST_WR_DATA, ST_WR_HIGH, ST_WR_LOW, ST_WR_REL, ST_WR_ACK, ST_WR_ACK_HOLD,
    ST_WR_END,
    ST_RD_BEGIN, ST_RD_LOW, ST_RD_HIGH, ST_RD_ACK_SET, ST_RD_ACK_RISE, ST_RD_ACK_FALL,
    ST_RD_END
  } bus_phase_t;

  // predicted sequencer state and its copy of the registers
  bus_phase_t       phase;
  logic [CFG_W-1:0] hold_cfg;
  logic [CFG_W-1:0] ack_limit_cfg;
  logic [15:0]      hold_cnt;
  logic [3:0]       bit_cnt;
  logic [7:0]       shreg;
  logic             nack_q;
  logic             ack_q;
  logic             scl_q;
  logic             sda_q;
  logic [7:0]       rx_q;

  out_word_t expected_levels[$];

  function automatic void arm(input bus_phase_t nxt);
    phase    = nxt;
    hold_cnt = hold_cfg;
  endfunction

  // step taken once a hold has run out; returns 1 when the command completes
  function automatic logic advance_phase(input logic sda_in);
    case (phase)
      ST_STA_RISE:    begin scl_q = 1'b1; arm(ST_STA_SDA_LOW); end
      ST_STA_SDA_LOW: begin sda_q = 1'b0; arm(ST_STA_SCL_LOW); end
      ST_STA_SCL_LOW: begin scl_q = 1'b0; arm(ST_STA_END); end
      ST_STO_RISE:    begin scl_q = 1'b1; arm(ST_STO_SDA_REL); end
      ST_STO_SDA_REL: begin sda_q = 1'b1; arm(ST_STO_END); end
      ST_WR_BEGIN, ST_WR_LOW: begin
        if (bit_cnt < BYTE_BITS) begin
          sda_q   = shreg[7];
          shreg   = {shreg[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          arm(ST_WR_DATA);
        end else begin
          sda_q = 1'b1;
          arm(ST_WR_REL);
        end
      end
      ST_WR_DATA:     begin scl_q = 1'b1; arm(ST_WR_HIGH); end
      ST_WR_HIGH:     begin scl_q = 1'b0; arm(ST_WR_LOW); end
      ST_WR_REL: begin
        scl_q    = 1'b1;
        phase    = ST_WR_ACK;
        hold_cnt = '0;
      end
      ST_WR_ACK_HOLD: begin scl_q = 1'b0; arm(ST_WR_END); end
      ST_RD_BEGIN:    begin scl_q = 1'b0; arm(ST_RD_LOW); end
      ST_RD_LOW:      begin scl_q = 1'b1; arm(ST_RD_HIGH); end
      ST_RD_HIGH: begin
        shreg   = {shreg[6:0], sda_in};
        bit_cnt = bit_cnt + 4'd1;
        scl_q   = 1'b0;
        if (bit_cnt < BYTE_BITS) arm(ST_RD_LOW);
        else arm(ST_RD_ACK_SET);
      end
      ST_RD_ACK_SET:  begin sda_q = nack_q; arm(ST_RD_ACK_RISE); end
      ST_RD_ACK_RISE: begin scl_q = 1'b1; arm(ST_RD_ACK_FALL); end
      ST_RD_ACK_FALL: begin scl_q = 1'b0; arm(ST_RD_END); end
      ST_RD_END: begin
        rx_q     = shreg;
        phase    = ST_IDLE;
        hold_cnt = '0;
        return 1'b1;
      end
      default: begin
        phase    = ST_IDLE;
        hold_cnt = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic out_word_t predict_bus_tick(input in_word_t w);
    out_word_t r;
    logic      fin;
    fin = 1'b0;
    if (phase == ST_IDLE) begin
      if (w.cmd_valid) begin
        case (cmd_t'(w.cmd))
          CMD_START: begin sda_q = 1'b1; arm(ST_STA_RISE); end
          CMD_STOP:  begin sda_q = 1'b0; arm(ST_STO_RISE); end
          CMD_WRITE: begin
            shreg   = w.tx_byte;
            bit_cnt = '0;
            ack_q   = 1'b0;
            scl_q   = 1'b0;
            arm(ST_WR_BEGIN);
          end
          default: begin
            nack_q  = w.send_nack;
            shreg   = '0;
            bit_cnt = '0;
            sda_q   = 1'b1;
            arm(ST_RD_BEGIN);
          end
        endcase
      end
    end else if (phase == ST_WR_ACK) begin
      if (!w.sda_in) begin
        ack_q = 1'b1;
        arm(ST_WR_ACK_HOLD);
      end else if (hold_cnt >= ack_limit_cfg) begin
        ack_q = 1'b0;
        arm(ST_WR_ACK_HOLD);
      end else begin
        hold_cnt = hold_cnt + 16'd1;
      end
    end else if (hold_cnt > 16'd1) begin
      hold_cnt = hold_cnt - 16'd1;
    end else begin
      fin = advance_phase(w.sda_in);
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (phase != ST_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.ack_seen  = ack_q;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endfunction

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      phase         = ST_IDLE;
      hold_cfg      = HOLD_TICKS_RST;
      ack_limit_cfg = ACK_WAIT_RST;
      hold_cnt      = '0;
      bit_cnt       = '0;
      shreg         = '0;
      nack_q        = 1'b0;
      ack_q         = 1'b0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      rx_q          = '0;
      expected_levels.delete();
    end else begin
      // compare before pushing, so a word can never meet its own prediction early
      if (out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t ns: result word with none expected, actual %0h", $time, out_data);
        end else begin
          want = expected_levels.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(out_data.sda_level));
          check_field("busy_res",  8'(want.busy_res),  8'(out_data.busy_res));
          check_field("done_res",  8'(want.done_res),  8'(out_data.done_res));
          check_field("rx_byte",   want.rx_byte,       out_data.rx_byte);
          check_field("ack_seen",  8'(want.ack_seen),  8'(out_data.ack_seen));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HOLD_TICKS: hold_cfg      = cfg_wdata;
          CFG_ACK_WAIT:   ack_limit_cfg = cfg_wdata;
        endcase
      end
      if (in_valid && in_ready) expected_levels.push_back(predict_bus_tick(in_data));
    end
    pending_results = expected_levels.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the I2C master bit sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import i2cbs_pkg::*;

  localparam int unsigned SEG_WORDS    = 80;   // words per random segment, six segments
  localparam int unsigned STALL_CYCLES = 200;  // length of the long sink hold-off

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int          mismatches;
  int          pending_results;
  int unsigned taken        = 0;    // words accepted on the input channel
  int unsigned results_seen = 0;    // words taken off the result channel
  logic        last_busy    = 1'b0; // busy flag of the latest result word
  logic        gaps_on      = 1'b1; // both sides idle at random while set
  int unsigned stall_reqs   = 0;
  int unsigned stall_served = 0;

  i2cbs_chan_if #(.T(in_word_t))  in_ch ();
  i2cbs_chan_if #(.T(out_word_t)) out_ch ();

  i2c_master_bit_sequencer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  i2cbs_bus_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Track the result stream only to pace the stimulus: the checker does the judging.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      last_busy    <= out_ch.data.busy_res;
    end
  end

  // Sink side: drop ready about a third of the time, and serve a long hold-off when one is
  // requested so that the result register stays full and the input backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_served) begin
        stall_served = stall_reqs;
        out_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 32);
    end
  end

  // One tick word with random content; low_pct sets how often the slave pulls SDA low and
  // cmd_pct how often a command is offered.
  function automatic in_word_t bus_tick_word(input int unsigned low_pct,
                                             input int unsigned cmd_pct);
    in_word_t w;
    w.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
    w.cmd       = 2'($urandom_range(0, 3));
    w.tx_byte   = 8'($urandom_range(0, 255));
    w.send_nack = 1'($urandom_range(0, 1));
    w.sda_in    = ($urandom_range(0, 99) >= low_pct);
    return w;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high on return, so
  // back-to-back words go out without a gap unless the random idling inserts one.
  task automatic offer_tick(input in_word_t w);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    taken++;
  endtask

  // Keep ticking until a word sent from here on comes back with the sequencer idle. The first
  // few ticks may carry commands: every command lasts longer than that, so they hit a busy
  // sequencer and must be ignored.
  task automatic run_until_idle(input int unsigned low_pct, input int unsigned noisy);
    int unsigned mark;
    int unsigned n;
    mark = taken;
    n    = 0;
    do begin
      offer_tick(bus_tick_word(low_pct, (n < noisy) ? 50 : 0));
      n++;
    end while (!(results_seen > mark && !last_busy));
  endtask

  // Issue one command to an idle sequencer and tick it through to completion.
  task automatic run_command(input cmd_t op, input logic [7:0] tx, input logic nack,
                             input int unsigned low_pct);
    in_word_t w;
    w           = bus_tick_word(low_pct, 0);
    w.cmd_valid = 1'b1;
    w.cmd       = op;
    w.tx_byte   = tx;
    w.send_nack = nack;
    offer_tick(w);
    run_until_idle(low_pct, 3);
  endtask

  // Drain the pipe completely: sequencer idle, valid dropped and every result word back.
  task automatic quiesce();
    run_until_idle(50, 0);
    in_ch.valid <= 1'b0;
    while (results_seen != taken) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] ack_limit);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HOLD_TICKS;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_idx   <= CFG_ACK_WAIT;
    cfg_wdata <= ack_limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // A well-formed transfer: start, one to three writes, reads or repeated starts, stop.
  // Most writes see an ACK at a random tick; a quarter see SDA high and run into the limit.
  task automatic run_transfer();
    int unsigned n;
    int unsigned pick;
    run_command(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
    n = $urandom_range(1, 3);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) == 0) ? 0 : 60);
      else if (pick < 90)
        run_command(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
      else
        run_command(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
    end
    run_command(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
  endtask

  // A burst of ticks with commands offered at any moment, idle or not, then settle.
  task automatic run_noise();
    int unsigned n;
    n = $urandom_range(5, 40);
    repeat (n) offer_tick(bus_tick_word(50, 25));
    run_until_idle(50, 0);
  endtask

  initial begin
    int unsigned seg_start;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_HOLD_TICKS;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of both registers: an all-ones byte with an ACK, a read of all zeros
    // with NAK, then stop.
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'hFF, 1'b0, 100);
    run_command(CMD_READ,  8'h00, 1'b1, 100);
    run_command(CMD_STOP,  8'h00, 1'b0, 50);

    // Zero hold must behave as one tick; a zero wait limit gives up on the first high
    // sample of the ACK slot.
    quiesce();
    set_config(16'd0, 16'd0);
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'hC3, 1'b0, 0);
    run_command(CMD_WRITE, 8'h3C, 1'b0, 100);
    run_command(CMD_READ,  8'h00, 1'b1, 50);
    run_command(CMD_STOP,  8'h00, 1'b0, 50);

    // A wait limit wider than a byte, with idling off: a write left unanswered runs the
    // ACK counter all the way out.
    quiesce();
    gaps_on = 1'b0;
    set_config(16'd1, 16'd300);
    run_command(CMD_START, 8'h00, 1'b0, 50);
    run_command(CMD_WRITE, 8'hA5, 1'b0, 0);
    run_command(CMD_STOP, 8'h00, 1'b0, 50);
    gaps_on = 1'b1;

    // Random segments, each under its own register setting; the second one opens with the
    // long sink hold-off and the fifth runs with no idling on either side.
    for (int seg = 0; seg < 6; seg++) begin
      quiesce();
      case (seg)
        0: set_config(16'd1, 16'd1);
        1: set_config(16'd2, 16'd3);
        2: set_config(16'd0, 16'd6);
        3: set_config(16'($urandom_range(1, 4)), 16'($urandom_range(0, 10)));
        4: set_config(16'd1, 16'd2);
        default: set_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 10)));
      endcase
      gaps_on = (seg != 4);
      if (seg == 1) stall_reqs++;
      seg_start = taken;
      while (taken - seg_start < SEG_WORDS) begin
        if ($urandom_range(0, 99) < 80) run_transfer();
        else run_noise();
      end
    end
    gaps_on = 1'b1;

    // Wait for the last result word, then for anything stray.
    quiesce();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- i2c_master_bit_sequencer_unit.f -----
rtl/i2cbs_pkg.sv
rtl/i2cbs_chan_if.sv
rtl/i2c_master_bit_sequencer_unit.sv
rtl/i2cbs_checker.sv
test/i2cbs_bus_checker.sv
test/tb_top.sv
